>>> src/ostq_pkg.sv
// Package for the one-shot timer queue: widths, codes and shared types.
// No dependencies.
package ostq_pkg;
  localparam int SLOTS = 16;
  localparam int SW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam int MAX_FIRE = SLOTS - 1;

  localparam logic [1:0] ACT_REG = 2'd0;
  localparam logic [1:0] ACT_REM = 2'd1;
  localparam logic [1:0] ACT_TICK = 2'd2;

  localparam logic [1:0] KIND_REG = 2'd0;
  localparam logic [1:0] KIND_REM = 2'd1;
  localparam logic [1:0] KIND_EXP = 2'd2;

  localparam logic [1:0] CFG_ENABLE = 2'd0;
  localparam logic [1:0] CFG_STEP = 2'd1;
  localparam logic [1:0] CFG_MARGIN = 2'd2;

  typedef struct packed {
    logic [1:0] action;
    logic [31:0] delay_us;
    logic [3:0] slot_request;
  } req_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] slot_id;
    logic status;
    logic last;
  } rsp_t;

  // Controller commands to the datapath.
  typedef struct packed {
    logic load;    // capture the request
    logic exec;    // perform register or remove, advance time on a tick
    logic fire;    // pop the queue head
  } cmd_t;

  // Datapath status to the controller.
  typedef struct packed {
    logic head_due;  // queue nonempty and head deadline below limit
    logic enable;
  } sts_t;
endpackage

>>> src/ostq_if.sv
// Valid/ready channel carrying one payload.
// Depends on ostq_pkg for nothing; payload type is a type parameter.
interface ostq_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> src/ostq_dp.sv
// Datapath: time, deadlines, busy bits, hand and the sorted slot order.
// Depends on ostq_pkg.
module ostq_dp (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [19:0] cfg_data,
  input  ostq_pkg::req_t req,
  input  ostq_pkg::cmd_t cmd,
  output ostq_pkg::sts_t sts,
  output ostq_pkg::rsp_t rsp_reg,
  output ostq_pkg::rsp_t rsp_fire
);
  logic enable;
  logic [19:0] step;
  logic [15:0] margin;
  logic [63:0] now_us, limit;
  logic [63:0] deadline [ostq_pkg::SLOTS];
  logic [ostq_pkg::SLOTS-1:0] busy;
  logic [ostq_pkg::SW-1:0] order [ostq_pkg::SLOTS];
  logic [ostq_pkg::CW-1:0] cnt;
  logic [ostq_pkg::SW-1:0] hand;
  ostq_pkg::req_t r;

  // Hand search: first free nonzero slot starting at the hand.
  logic [ostq_pkg::SW-1:0] got, hand_after;
  logic found;
  logic [63:0] due;
  logic [ostq_pkg::SLOTS-1:0] le;
  logic [ostq_pkg::CW-1:0] pos, rpos;
  logic rem_ok;

  function automatic logic [ostq_pkg::SW-1:0] nh(input logic [ostq_pkg::SW-1:0] h);
    logic [ostq_pkg::SW-1:0] n;
    n = h + 1'b1;
    return (n == '0) ? {{(ostq_pkg::SW-1){1'b0}}, 1'b1} : n;
  endfunction

  always_comb begin
    logic [ostq_pkg::SW-1:0] h;
    h = hand;
    got = '0;
    found = 1'b0;
    hand_after = hand;
    for (int i = 0; i < ostq_pkg::SLOTS; i++) begin
      if (!found) begin
        if (h != '0 && !busy[h]) begin
          got = h;
          found = 1'b1;
        end
        h = nh(h);
        hand_after = h;
      end
    end
  end

  assign due = now_us + ((r.delay_us == '0) ? 64'd1 : {32'd0, r.delay_us});

  // Insert position: count of queued entries with deadline <= due.
  always_comb begin
    pos = '0;
    rpos = '0;
    for (int i = 0; i < ostq_pkg::SLOTS; i++) begin
      le[i] = (ostq_pkg::CW'(i) < cnt) && (deadline[order[i]] <= due);
      if (le[i]) pos = ostq_pkg::CW'(i + 1);
      if ((ostq_pkg::CW'(i) < cnt) && order[i] == r.slot_request[ostq_pkg::SW-1:0])
        rpos = ostq_pkg::CW'(i);
    end
  end

  assign rem_ok = (r.slot_request != 4'd0) && ({28'd0, r.slot_request} < ostq_pkg::SLOTS)
                  && busy[r.slot_request[ostq_pkg::SW-1:0]];
  wire reg_ok = enable && (cnt < ostq_pkg::CW'(ostq_pkg::SLOTS - 1)) && found;

  assign limit = now_us + {48'd0, margin};
  assign sts.head_due = (cnt != '0) && (deadline[order[0]] < limit);
  assign sts.enable = enable;

  always_comb begin
    rsp_reg = '0;
    rsp_reg.last = 1'b1;
    if (r.action == ostq_pkg::ACT_REG) begin
      rsp_reg.kind = ostq_pkg::KIND_REG;
      rsp_reg.slot_id = reg_ok ? 4'(got) : 4'd0;
      rsp_reg.status = !reg_ok;
    end else begin
      rsp_reg.kind = ostq_pkg::KIND_REM;
      rsp_reg.slot_id = r.slot_request;
      rsp_reg.status = !rem_ok;
    end
    rsp_fire = '0;
    rsp_fire.kind = ostq_pkg::KIND_EXP;
    rsp_fire.slot_id = 4'(order[0]);
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      enable <= 1'b0;
      step <= 20'd10000;
      margin <= 16'd2000;
    end else if (cfg_we) begin
      case (cfg_index)
        ostq_pkg::CFG_ENABLE: enable <= cfg_data[0];
        ostq_pkg::CFG_STEP: step <= cfg_data;
        ostq_pkg::CFG_MARGIN: margin <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) r <= req;
  end

  // Queue state.
  always_ff @(posedge clk) begin
    if (rst) begin
      now_us <= '0;
      busy <= '0;
      cnt <= '0;
      hand <= {{(ostq_pkg::SW-1){1'b0}}, 1'b1};
    end else if (cmd.exec) begin
      case (r.action)
        ostq_pkg::ACT_REG: begin
          if (enable && cnt < ostq_pkg::CW'(ostq_pkg::SLOTS - 1)) begin
            hand <= hand_after;
            if (found) begin
              busy[got] <= 1'b1;
              deadline[got] <= due;
              for (int i = 1; i < ostq_pkg::SLOTS; i++) begin
                if (ostq_pkg::CW'(i) > pos && ostq_pkg::CW'(i) <= cnt) order[i] <= order[i-1];
              end
              order[pos[ostq_pkg::SW-1:0]] <= got;
              cnt <= cnt + 1'b1;
            end
          end
        end
        ostq_pkg::ACT_REM: begin
          if (rem_ok) begin
            busy[r.slot_request[ostq_pkg::SW-1:0]] <= 1'b0;
            for (int i = 0; i < ostq_pkg::SLOTS - 1; i++) begin
              if (ostq_pkg::CW'(i) >= rpos) order[i] <= order[i+1];
            end
            cnt <= cnt - 1'b1;
          end
        end
        ostq_pkg::ACT_TICK: now_us <= now_us + {44'd0, step};
        default: ;
      endcase
    end else if (cmd.fire) begin
      busy[order[0]] <= 1'b0;
      for (int i = 0; i < ostq_pkg::SLOTS - 1; i++) order[i] <= order[i+1];
      cnt <= cnt - 1'b1;
    end
  end
endmodule

>>> src/ostq_ctrl.sv
// Controller: sequences request capture, execution, reply and expiry firing.
// Depends on ostq_pkg.
module ostq_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [1:0] in_action,
  output logic out_valid,
  input  logic out_ready,
  output ostq_pkg::rsp_t out_data,
  input  ostq_pkg::sts_t sts,
  input  ostq_pkg::rsp_t rsp_reg,
  input  ostq_pkg::rsp_t rsp_fire,
  output ostq_pkg::cmd_t cmd
);
  typedef enum logic [1:0] {IDLE, EXEC, FIRE, WAIT} state_t;
  state_t state;
  logic [1:0] act;
  logic [ostq_pkg::SW-1:0] nfired;

  wire out_free = !out_valid || out_ready;

  // A reply is presented after a register or remove, and after each expiry's last check.
  wire set_valid = ((state == EXEC) && out_free
                    && (act == ostq_pkg::ACT_REG || act == ostq_pkg::ACT_REM))
                   || (state == WAIT);

  always_comb begin
    cmd = '0;
    in_ready = (state == IDLE);
    cmd.load = in_valid && in_ready;
    cmd.exec = (state == EXEC) && out_free;
    cmd.fire = (state == FIRE) && out_free && sts.head_due
               && (32'(nfired) < ostq_pkg::MAX_FIRE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      out_valid <= 1'b0;
      act <= '0;
      nfired <= '0;
    end else begin
      out_valid <= set_valid || (out_valid && !out_ready);
      case (state)
        IDLE: begin
          if (cmd.load) begin
            act <= in_action;
            state <= EXEC;
          end
        end
        EXEC: begin
          if (out_free) begin
            nfired <= '0;
            if (act == ostq_pkg::ACT_REG || act == ostq_pkg::ACT_REM) begin
              out_data <= rsp_reg;
              state <= IDLE;
            end else if (act == ostq_pkg::ACT_TICK && sts.enable) begin
              state <= FIRE;
            end else begin
              state <= IDLE;
            end
          end
        end
        FIRE: begin
          // Hold each expiry until the next head is known so last is exact.
          if (out_free) begin
            if (cmd.fire) begin
              out_data <= rsp_fire;
              nfired <= nfired + 1'b1;
              state <= WAIT;
            end else begin
              state <= IDLE;
            end
          end
        end
        WAIT: begin
          out_data.last <= !(sts.head_due && (32'(nfired) < ostq_pkg::MAX_FIRE));
          state <= FIRE;
        end
        default: state <= IDLE;
      endcase
    end
  end
endmodule

>>> src/one_shot_timer_queue_core.sv
// One-shot timer queue over SLOTS slots with a deadline-sorted order.
// A register or remove is captured, executed and its reply registered; a
// tick is captured, advances time, then pops each expiry and re-checks the
// head for last. A new request waits until the controller is idle again.
// Reset: synchronous, active high; clears time, busy bits, count, hand=1.
// Depends on ostq_pkg, ostq_if, ostq_ctrl, ostq_dp.
module one_shot_timer_queue_core (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [19:0] cfg_data,
  ostq_if.sink in_ch,
  ostq_if.source out_ch
);
  ostq_pkg::cmd_t cmd;
  ostq_pkg::sts_t sts;
  ostq_pkg::rsp_t rsp_reg, rsp_fire, od;
  ostq_pkg::req_t req;

  assign req.action = in_ch.data.action;
  assign req.delay_us = in_ch.data.delay_us;
  assign req.slot_request = in_ch.data.slot_request;

  ostq_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_action(in_ch.data.action),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(od),
    .sts(sts), .rsp_reg(rsp_reg), .rsp_fire(rsp_fire), .cmd(cmd)
  );

  ostq_dp u_dp (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .req(req), .cmd(cmd), .sts(sts), .rsp_reg(rsp_reg), .rsp_fire(rsp_fire)
  );

  assign out_ch.data = od;
endmodule

>>> tb/tb_top.sv
// Self-checking testbench for one_shot_timer_queue_core.
// Depends on ostq_pkg and ostq_if; a scoreboard class predicts every reply and expiry.
`timescale 1ns / 1ps

module tb_top;

  // Scoreboard: own copy of the timer queue, predicts results per accepted request.
  class timer_scoreboard;
    logic        en;
    logic [19:0] step_us;
    logic [15:0] margin_us;
    logic [63:0] now_us;
    logic [63:0] due_at [ostq_pkg::SLOTS];
    logic        busy [ostq_pkg::SLOTS];
    logic [3:0]  queue_slot [ostq_pkg::SLOTS];
    int          queued;
    logic [3:0]  hand;
    ostq_pkg::rsp_t expected_q [$];
    int          errors;

    function new();
      en = 1'b0;
      step_us = 20'd10000;
      margin_us = 16'd2000;
      now_us = '0;
      queued = 0;
      hand = 4'd1;
      errors = 0;
      for (int i = 0; i < ostq_pkg::SLOTS; i++) begin
        due_at[i] = '0;
        busy[i] = 1'b0;
        queue_slot[i] = '0;
      end
    endfunction

    function void set_reg(logic [1:0] idx, logic [19:0] val);
      case (idx)
        ostq_pkg::CFG_ENABLE: en = val[0];
        ostq_pkg::CFG_STEP:   step_us = val;
        ostq_pkg::CFG_MARGIN: margin_us = val[15:0];
        default: ;
      endcase
    endfunction

    function void push(logic [1:0] kind, logic [3:0] slot, logic st, logic lst);
      ostq_pkg::rsp_t r;
      r.kind = kind;
      r.slot_id = slot;
      r.status = st;
      r.last = lst;
      expected_q.push_back(r);
    endfunction

    // Work out the results of one accepted request.
    function void note_request(ostq_pkg::req_t r);
      logic [63:0] due, lim;
      logic [3:0]  got, s;
      int          pos, n;
      ostq_pkg::rsp_t last_r;
      case (r.action)
        ostq_pkg::ACT_REG: begin
          due = now_us + ((r.delay_us == 0) ? 64'd1 : {32'd0, r.delay_us});
          got = '0;
          if (en && queued < ostq_pkg::SLOTS - 1) begin
            for (int i = 0; i < ostq_pkg::SLOTS && got == 0; i++) begin
              if (hand != 0 && !busy[hand]) got = hand;
              hand = hand + 4'd1;
              if (hand == 0) hand = 4'd1;
            end
          end
          if (got == 0) begin
            push(ostq_pkg::KIND_REG, 4'd0, 1'b1, 1'b1);
          end else begin
            busy[got] = 1'b1;
            due_at[got] = due;
            pos = 0;
            while (pos < queued && due_at[queue_slot[pos]] <= due) pos++;
            for (int j = queued; j > pos; j--) queue_slot[j] = queue_slot[j-1];
            queue_slot[pos] = got;
            queued++;
            push(ostq_pkg::KIND_REG, got, 1'b0, 1'b1);
          end
        end
        ostq_pkg::ACT_REM: begin
          if (r.slot_request == 0 || !busy[r.slot_request]) begin
            push(ostq_pkg::KIND_REM, r.slot_request, 1'b1, 1'b1);
          end else begin
            for (int i = 0; i < queued; i++) begin
              if (queue_slot[i] == r.slot_request) begin
                for (int j = i; j + 1 < queued; j++) queue_slot[j] = queue_slot[j+1];
                queued--;
                break;
              end
            end
            busy[r.slot_request] = 1'b0;
            due_at[r.slot_request] = '0;
            push(ostq_pkg::KIND_REM, r.slot_request, 1'b0, 1'b1);
          end
        end
        ostq_pkg::ACT_TICK: begin
          now_us = now_us + {44'd0, step_us};
          if (en) begin
            lim = now_us + {48'd0, margin_us};
            n = 0;
            while (n < ostq_pkg::MAX_FIRE && queued > 0 && due_at[queue_slot[0]] < lim) begin
              s = queue_slot[0];
              for (int j = 0; j + 1 < queued; j++) queue_slot[j] = queue_slot[j+1];
              queued--;
              busy[s] = 1'b0;
              due_at[s] = '0;
              push(ostq_pkg::KIND_EXP, s, 1'b0, 1'b0);
              n++;
            end
            // The final expiry of this tick carries last.
            if (n > 0) begin
              last_r = expected_q.pop_back();
              last_r.last = 1'b1;
              expected_q.push_back(last_r);
            end
          end
        end
        default: ;
      endcase
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      errors++;
    endtask

    // Compare one observed result with the oldest expectation.
    task check_result(ostq_pkg::rsp_t got);
      ostq_pkg::rsp_t exp;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result kind=%0d slot=%0d", got.kind, got.slot_id));
      end else begin
        exp = expected_q.pop_front();
        if (got.kind !== exp.kind)
          report($sformatf("kind %0d, expected %0d", got.kind, exp.kind));
        if (got.slot_id !== exp.slot_id)
          report($sformatf("slot_id %0d, expected %0d", got.slot_id, exp.slot_id));
        if (got.status !== exp.status)
          report($sformatf("status %0d, expected %0d", got.status, exp.status));
        if (got.last !== exp.last)
          report($sformatf("last %0d, expected %0d", got.last, exp.last));
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [19:0] cfg_data;

  ostq_if #(.T(ostq_pkg::req_t)) req_ch ();
  ostq_if #(.T(ostq_pkg::rsp_t)) rsp_ch ();

  one_shot_timer_queue_core dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_ch(req_ch),
    .out_ch(rsp_ch)
  );

  timer_scoreboard sb = new();
  int burst_left = 0;
  logic [15:0] stall_pat = 16'hFFFF;
  int stall_left = 0;
  logic [3:0] stall_phase = '0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Receiver stalls follow a pattern that changes every so often.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_left <= $urandom_range(20, 200);
      stall_pat <= ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom);
    end else begin
      stall_left <= stall_left - 1;
    end
    stall_phase <= stall_phase + 4'd1;
    rsp_ch.ready <= rst ? 1'b0 : stall_pat[stall_phase];
  end

  // Result monitor.
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) sb.check_result(rsp_ch.data);
  end

  // Send one request, in bursts with random gaps between them.
  task send_request(logic [1:0] act, logic [31:0] dly, logic [3:0] slot);
    ostq_pkg::req_t r;
    int gap;
    r.action = act;
    r.delay_us = dly;
    r.slot_request = slot;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    req_ch.valid <= 1'b1;
    req_ch.data <= r;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sb.note_request(r);
    burst_left--;
  endtask

  // Register write once the block has drained.
  task write_reg(logic [1:0] idx, logic [19:0] val);
    req_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    sb.set_reg(idx, val);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task apply_setting(logic en, logic [19:0] step, logic [15:0] margin);
    write_reg(ostq_pkg::CFG_ENABLE, {19'd0, en});
    write_reg(ostq_pkg::CFG_STEP, step);
    write_reg(ostq_pkg::CFG_MARGIN, {4'd0, margin});
  endtask

  // Random requests, mostly meaningful ones against the predicted state.
  task random_phase(int count);
    int pick, busy_n;
    logic [31:0] dly;
    logic [3:0] slot;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 3) == 0) dly = $urandom;
      else dly = $urandom_range(0, 4 * sb.step_us + sb.margin_us + 2);
      slot = 4'($urandom);
      if ($urandom_range(0, 1) == 0) begin
        busy_n = 0;
        for (int i = 1; i < ostq_pkg::SLOTS; i++) if (sb.busy[i]) busy_n++;
        if (busy_n > 0) begin
          do slot = 4'($urandom_range(1, ostq_pkg::SLOTS - 1)); while (!sb.busy[slot]);
        end
      end
      if (pick < 40) send_request(ostq_pkg::ACT_REG, dly, slot);
      else if (pick < 63) send_request(ostq_pkg::ACT_REM, dly, slot);
      else if (pick < 95) send_request(ostq_pkg::ACT_TICK, dly, slot);
      else send_request(2'd3, dly, slot);
    end
  endtask

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    req_ch.valid <= 1'b0;
    req_ch.data <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Disabled block: registration fails, removes of bad slots fail, ticks fire nothing.
    send_request(ostq_pkg::ACT_REG, 32'd5, 4'd0);
    send_request(ostq_pkg::ACT_REM, 32'd0, 4'd0);
    send_request(ostq_pkg::ACT_REM, 32'd0, 4'd15);
    send_request(ostq_pkg::ACT_TICK, 32'hFFFF_FFFF, 4'd7);
    send_request(2'd3, 32'hFFFF_FFFF, 4'd15);

    // Fill the queue: zero delay, largest delay, then equal deadlines.
    write_reg(ostq_pkg::CFG_ENABLE, 20'd1);
    send_request(ostq_pkg::ACT_REG, 32'd0, 4'd0);
    send_request(ostq_pkg::ACT_REG, 32'hFFFF_FFFF, 4'd0);
    for (int i = 0; i < 13; i++) send_request(ostq_pkg::ACT_REG, 32'd1000, 4'd0);
    send_request(ostq_pkg::ACT_REG, 32'd1, 4'd0);
    send_request(ostq_pkg::ACT_REM, 32'd0, 4'd2);
    send_request(ostq_pkg::ACT_REM, 32'd0, 4'd2);
    send_request(ostq_pkg::ACT_TICK, 32'd0, 4'd0);
    send_request(ostq_pkg::ACT_TICK, 32'd0, 4'd0);

    apply_setting(1'b1, 20'd10000, 16'd2000);
    random_phase(42);
    apply_setting(1'b1, 20'd1, 16'd0);
    random_phase(42);
    apply_setting(1'b1, 20'd1000000, 16'd65535);
    random_phase(42);
    // Disabled with timers pending: the queue is kept.
    apply_setting(1'b0, 20'd500, 16'd100);
    random_phase(30);
    apply_setting(1'b1, 20'd0, 16'd65535);
    random_phase(42);
    apply_setting(1'b1, 20'd2500, 16'd300);
    random_phase(42);

    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #40_000_000;
    $display("Mismatches found");
    $finish;
  end
endmodule
